### rtl/tsd_pkg.sv
// shared types and constants for the thermometer scratchpad decoder
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package tsd_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int LAST_INDEX  = FRAME_BYTES - 1;
	localparam int DIV_STEPS   = 16;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	localparam logic [7:0] FAM_S20  = 8'h10;
	localparam logic [7:0] FAM_22   = 8'h22;
	localparam logic [7:0] FAM_28   = 8'h28;
	localparam logic [7:0] FAM_3B   = 8'h3B;
	localparam logic [7:0] FAM_42   = 8'h42;
	localparam logic [7:0] CFG_MASK = 8'h9F;
	localparam logic [7:0] CFG_WANT = 8'h1F;
	localparam logic [7:0] CFG_BIT4 = 8'h10;
	localparam logic [7:0] CRC_POLY = 8'h8C;
	localparam logic [7:0] FAM_RESET = 8'h28;
	localparam logic [15:0] RAW_MASK = 16'hFFF0;
	localparam logic [15:0] HALF_OFS = 16'd16;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic emit;
	} tsd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_byte;
	} tsd_status_t;

endpackage

`default_nettype wire

### rtl/tsd_ctrl.sv
// controller state machine: sequences byte accept, divider iterations and result
// depends on tsd_pkg
`default_nettype none

module tsd_ctrl import tsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  tsd_status_t      status,
	output tsd_cmd_t         cmd,
	output logic             busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	always_comb begin
		cmd.accept   = (state_q == ST_IDLE) && start;
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit     = (state_q == ST_OUT);
		busy         = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start && status.last_byte) state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/tsd_dpath.sv
// datapath: byte store, running crc, family register, restoring divider, result
// depends on tsd_pkg
`default_nettype none

module tsd_dpath import tsd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  tsd_cmd_t          cmd,
	output tsd_status_t       status,
	input  wire logic         frame_start,
	input  wire logic [7:0]   data_byte,
	input  wire logic         cfg_we,
	input  wire logic [7:0]   cfg_data,
	output logic              done,
	output logic signed [15:0] temperature,
	output logic              checksum_ok,
	output logic              config_ok,
	output logic              count_ok,
	output logic              valid_res,
	output logic              model_supported
);

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [3:0] count_q;
	logic [7:0] crc_q;
	logic [7:0] family_q;
	logic [7:0] pad_q [FRAME_BYTES];
	logic       chk_q;
	logic [15:0] quo_q;
	logic [7:0]  rem_q;
	logic        neg_q;

	logic [3:0] eff_count;
	logic [8:0] diff;
	logic [8:0] diff_mag;
	logic [8:0] shifted;
	logic       fits;

	always_comb begin
		eff_count = (frame_start || (count_q >= 4'(FRAME_BYTES))) ? 4'd0 : count_q;
		status.last_byte = (eff_count == 4'(LAST_INDEX));
		// count per degree minus count remain, from stored bytes 7 and 6
		diff     = {1'b0, pad_q[7]} - {1'b0, pad_q[6]};
		diff_mag = diff[8] ? (9'd0 - diff) : diff;
		shifted  = {rem_q, quo_q[15]};
		fits     = (shifted >= {1'b0, pad_q[7]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= '0;
			family_q <= FAM_RESET;
			done     <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cfg_we) family_q <= cfg_data;
			if (cmd.accept) begin
				if (status.last_byte) begin
					count_q <= '0;
					crc_q   <= '0;
				end else begin
					count_q <= eff_count + 4'd1;
					crc_q   <= crc_byte((eff_count == 4'd0) ? 8'd0 : crc_q, data_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pad_q[eff_count] <= data_byte;
			if (status.last_byte) begin
				chk_q <= (crc_q == data_byte);
				neg_q <= diff[8];
				rem_q <= '0;
				quo_q <= {1'b0, diff_mag[7:0], 7'd0};
			end
		end
		if (cmd.div_step) begin
			rem_q <= fits ? 8'(shifted - {1'b0, pad_q[7]}) : shifted[7:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	logic [15:0] raw;
	logic [15:0] raw_masked;
	logic [15:0] quo_signed;
	logic [15:0] refined;
	logic        is_s20;
	logic        cfg_calc;
	logic        cnt_calc;

	always_comb begin
		raw        = {pad_q[1][4:0], 11'd0} | {5'd0, pad_q[0], 3'd0};
		raw_masked = raw & RAW_MASK;
		quo_signed = neg_q ? (16'd0 - quo_q) : quo_q;
		refined    = {raw_masked[12:0], 3'd0} - HALF_OFS + quo_signed;
		is_s20     = (family_q == FAM_S20);
		if (family_q == FAM_28) cfg_calc = ((pad_q[4] & CFG_MASK) == CFG_WANT);
		else                    cfg_calc = ((pad_q[4] & CFG_BIT4) == CFG_BIT4);
		cnt_calc   = !(is_s20 && (pad_q[7] == 8'd0));
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (!is_s20)        temperature <= signed'(raw);
			else if (!cnt_calc) temperature <= '0;
			else                temperature <= signed'(refined);
			checksum_ok     <= chk_q;
			config_ok       <= cfg_calc;
			count_ok        <= cnt_calc;
			valid_res       <= chk_q && cfg_calc && cnt_calc;
			model_supported <= (family_q == FAM_S20) || (family_q == FAM_22) ||
				(family_q == FAM_28) || (family_q == FAM_3B) || (family_q == FAM_42);
		end
	end

endmodule

`default_nettype wire

### rtl/thermometer_scratchpad_decoder_unit.sv
// top level of the thermometer scratchpad decoder
// depends on tsd_pkg, tsd_ctrl and tsd_dpath
`default_nettype none

// Scratchpad decoder for a one-wire thermometer. Feed the nine scratchpad
// bytes one item each, byte 0 first, with frame_start high on byte 0 (a mark
// mid-frame drops the partial frame; after a finished frame the next byte is
// byte 0 even without the mark). An item is taken at a clock edge with start
// high and busy low. Bytes 0 through 7 leave busy low. Byte 8 raises busy
// while the restoring divider runs its 16 iterations to refine the
// count-remain reading, and then while the result is registered.
// The result then shows for exactly one cycle with done high;
// the receiver cannot stall it, so it must take it in that cycle. busy is low
// again in that cycle and the next frame may begin at once. The family code
// register is written through cfg_valid/cfg_ready (always ready) and must
// only be changed while no frame is in flight. Temperature is in signed
// 1/128 degree units.

module thermometer_scratchpad_decoder_unit import tsd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// item channel
	input  wire logic          start,
	output logic               busy,
	input  wire logic          frame_start,
	input  wire logic [7:0]    data_byte,
	// family code register write
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [7:0]    cfg_data,
	// result, one cycle per frame
	output logic               done,
	output logic signed [15:0] temperature,
	output logic               checksum_ok,
	output logic               config_ok,
	output logic               count_ok,
	output logic               valid_res,
	output logic               model_supported
);

	tsd_cmd_t    cmd;
	tsd_status_t status;

	// register is eight bits wide, always writable
	assign cfg_ready = 1'b1;

	// sequencing: idle, divide iterations, result capture
	tsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// byte store, crc, divider and result registers
	tsd_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.frame_start     (frame_start),
		.data_byte       (data_byte),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.temperature     (temperature),
		.checksum_ok     (checksum_ok),
		.config_ok       (config_ok),
		.count_ok        (count_ok),
		.valid_res       (valid_res),
		.model_supported (model_supported)
	);

endmodule

`default_nettype wire

### tb/sv/thermometer_scratchpad_decoder_unit_test.sv
// self-checking testbench for thermometer_scratchpad_decoder_unit
// depends on tsd_pkg and the decoder rtl; predicts each decoded reading and checks it
`timescale 1ns / 1ps

module thermometer_scratchpad_decoder_unit_test;
	import tsd_pkg::*;

	// one scratchpad frame, byte 0 in the low slot
	typedef logic [8:0][7:0] frame_t;

	// one decoded reading as the block should show it
	typedef struct packed {
		logic signed [15:0] temperature;
		logic               checksum_ok;
		logic               config_ok;
		logic               count_ok;
		logic               valid_res;
		logic               model_supported;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic frame_start = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic cfg_valid = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic busy;
	logic cfg_ready;
	logic done;
	logic signed [15:0] temperature;
	logic checksum_ok;
	logic config_ok;
	logic count_ok;
	logic valid_res;
	logic model_supported;

	// mirror of the decoder state, updated on every accepted item
	logic [7:0] family_reg = FAM_RESET;
	int scratch_count = 0;
	logic [7:0] scratch_crc = 8'h00;
	frame_t scratch_bytes = '0;

	reading_t pending_readings[$];
	int mismatch_count = 0;
	int items_sent = 0;
	// chance in a hundred that the sender holds off once more
	int idle_pct = 0;

	thermometer_scratchpad_decoder_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.frame_start     (frame_start),
		.data_byte       (data_byte),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.done            (done),
		.temperature     (temperature),
		.checksum_ok     (checksum_ok),
		.config_ok       (config_ok),
		.count_ok        (count_ok),
		.valid_res       (valid_res),
		.model_supported (model_supported)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("thermometer_scratchpad_decoder_unit regression: fail");
		$finish;
	end

	// reflected crc-8, lsb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// put the matching checksum into byte 8
	function automatic frame_t seal_frame(input frame_t pad);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < LAST_INDEX; i++)
			c = crc8_update(c, pad[i]);
		pad[LAST_INDEX] = c;
		return pad;
	endfunction

	// track one accepted byte; on the last byte of a frame queue the reading
	task automatic absorb_byte(input logic mark, input logic [7:0] b);
		reading_t r;
		logic [15:0] raw;
		int quot;
		int t;
		// a start mark throws away whatever partial frame was collected
		if (mark) begin
			scratch_count = 0;
			scratch_crc = 8'h00;
		end
		scratch_bytes[scratch_count] = b;
		if (scratch_count < LAST_INDEX) begin
			scratch_crc = crc8_update(scratch_crc, b);
			scratch_count++;
		end else begin
			// ninth byte: the frame is complete, count wraps to zero
			scratch_count = 0;
			r.checksum_ok = (scratch_crc == b);
			scratch_crc = 8'h00;
			if (family_reg == FAM_28)
				r.config_ok = ((scratch_bytes[4] & CFG_MASK) == CFG_WANT);
			else
				r.config_ok = ((scratch_bytes[4] & CFG_BIT4) == CFG_BIT4);
			r.model_supported = (family_reg == FAM_S20) || (family_reg == FAM_22) ||
				(family_reg == FAM_28) || (family_reg == FAM_3B) || (family_reg == FAM_42);
			// msb byte bits 4:0 over lsb byte, scaled to 1/128 degree
			raw = {scratch_bytes[1][4:0], scratch_bytes[0], 3'b000};
			r.temperature = raw;
			r.count_ok = 1'b1;
			if (family_reg == FAM_S20) begin
				if (scratch_bytes[7] == 8'h00) begin
					// zero count per degree: no refinement possible
					r.count_ok = 1'b0;
					r.temperature = 16'sd0;
				end else begin
					// signed divide truncates toward zero
					quot = ((int'(scratch_bytes[7]) - int'(scratch_bytes[6])) * 128) /
						int'(scratch_bytes[7]);
					t = int'(raw & RAW_MASK) * 8 - int'(HALF_OFS) + quot;
					r.temperature = t[15:0];
				end
			end
			r.valid_res = r.checksum_ok & r.config_ok & r.count_ok;
			pending_readings.push_back(r);
		end
	endtask

	// offer one byte, with random hold-off, until the block takes it
	task automatic deliver_byte(input logic mark, input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		frame_start <= mark;
		data_byte <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		absorb_byte(mark, b);
		items_sent++;
		// start stays high; the next call or a drain decides its value
	endtask

	task automatic send_frame(input logic mark, input frame_t pad, input int n);
		for (int i = 0; i < n; i++)
			deliver_byte((i == 0) ? mark : 1'b0, pad[i]);
	endtask

	// stop offering items until every queued reading has shown up
	task automatic wait_readings_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_readings.size() != 0);
	endtask

	// family code may only change with no frame in flight
	task automatic program_family(input logic [7:0] v);
		wait_readings_drained();
		// let the divider settle past its longest run
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		family_reg = v;
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// every done pulse must match the oldest queued reading
	always @(posedge clk) begin
		reading_t r;
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected reading, expected none, got temperature %0d",
					$time, temperature);
				mismatch_count++;
			end else begin
				r = pending_readings.pop_front();
				check_field("temperature", r.temperature, temperature);
				check_field("checksum_ok", r.checksum_ok, checksum_ok);
				check_field("config_ok", r.config_ok, config_ok);
				check_field("count_ok", r.count_ok, count_ok);
				check_field("valid_res", r.valid_res, valid_res);
				check_field("model_supported", r.model_supported, model_supported);
			end
		end
	end

	// reset family, good crc, extreme bytes, negative raw reading
	task automatic test_clean_frame_extremes();
		frame_t pad;
		pad = {8'h00, 8'h10, 8'h0C, 8'hFF, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'hFF};
		send_frame(1'b1, seal_frame(pad), 9);
	endtask

	// mid-frame restart, then a refined-model frame with zero count per degree
	task automatic test_restart_zero_count();
		frame_t pad;
		program_family(FAM_S20);
		pad = {8'h00, 8'h00, 8'h05, 8'h10, 8'hEF, 8'h00, 8'h00, 8'h01, 8'h32};
		send_frame(1'b1, pad, 2);
		send_frame(1'b1, seal_frame(pad), 9);
	endtask

	// no start mark after a finished frame, negative refinement, bad crc
	task automatic test_missing_mark_negative_refine();
		frame_t pad;
		pad = seal_frame({8'h00, 8'h01, 8'hFF, 8'h55, 8'h00, 8'hAA, 8'h33, 8'h80, 8'h00});
		pad[LAST_INDEX] = ~pad[LAST_INDEX];
		send_frame(1'b0, pad, 9);
	endtask

	// mostly well-formed frames with random content, some broken or unsealed
	task automatic random_frame();
		frame_t pad;
		logic mark;
		int n;
		for (int i = 0; i < 9; i++)
			pad[i] = 8'($urandom_range(255));
		// half the frames carry a config byte the strict rule accepts
		if ($urandom_range(1) == 1)
			pad[4] = (pad[4] & ~CFG_MASK) | CFG_WANT;
		case ($urandom_range(5))
			0: pad[7] = 8'h00;
			1: pad[7] = pad[6];
			2: pad[6] = 8'h00;
			default: ;
		endcase
		if ($urandom_range(9) < 6)
			pad = seal_frame(pad);
		// a leftover partial frame forces a restart mark
		mark = (scratch_count != 0) || ($urandom_range(4) != 0);
		n = ($urandom_range(9) == 0) ? $urandom_range(1, LAST_INDEX) : 9;
		send_frame(mark, pad, n);
	endtask

	// one phase per family setting, cycling through the idle profiles
	task automatic test_random_families();
		logic [7:0] fam;
		int budget;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: fam = FAM_28;
				1: fam = FAM_S20;
				2: fam = FAM_22;
				3: fam = FAM_3B;
				4: fam = FAM_42;
				5: fam = 8'h00;
				6: fam = 8'hFF;
				default: fam = 8'($urandom_range(255));
			endcase
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 83;
				default: idle_pct = 11;
			endcase
			program_family(fam);
			budget = items_sent + 50;
			while (items_sent < budget || scratch_count != 0) begin
				if ($urandom_range(7) == 0)
					wait_readings_drained();
				random_frame();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clean_frame_extremes();
		test_restart_zero_count();
		test_missing_mark_negative_refine();
		test_random_families();
		wait_readings_drained();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("thermometer_scratchpad_decoder_unit regression: pass");
		else
			$display("thermometer_scratchpad_decoder_unit regression: fail");
		$finish;
	end

endmodule
